### hw/rtl/hhdc_pkg.sv
// shared types, constants and helper functions for the heading hold drive controller
// no dependencies; used by hhdc_heading_error and heading_hold_drive_controller

package hhdc_pkg;

   // sizing
   localparam int INTEGRAL_WIDTH = 24;
   localparam int GAIN_FRAC_BITS = 8;
   localparam int DECAY_STEPS    = 16;

   localparam int HEADING_W = 13;
   localparam int SPEED_W   = 8;
   localparam int GAIN_W    = 12;
   localparam int TOL_W     = 8;
   localparam int MODE_W    = 3;
   localparam int ERR_W     = 9;
   localparam int DIFF_W    = 10;
   localparam int DECAY_W   = 7;
   localparam int DECAY_IDX_W = 6;
   localparam int FACTOR_W  = 17;
   localparam int FACTOR_SHIFT = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
   localparam int PROD_I_W = GAIN_W + 1 + INTEGRAL_WIDTH;
   localparam int PROD_D_W = GAIN_W + 1 + DIFF_W;
   localparam int SUM_W    = PROD_I_W + 3;
   localparam int TURN_PROD_W = SPEED_W + FACTOR_W;

   // fixed numbers of the control law
   localparam int HALF_TURN_Q4 = 180 * 16;
   localparam int FULL_TURN    = 360;
   localparam int HALF_TURN    = 180;
   localparam int RIGHT_TRIM   = 3;
   localparam int TURN_FLOOR   = 35;
   localparam int SPEED_MAX    = 255;

   // register reset values
   localparam logic [GAIN_W-1:0] PROP_GAIN_RESET  = 12'd1075;
   localparam logic [GAIN_W-1:0] DERIV_GAIN_RESET = 12'd246;
   localparam logic [TOL_W-1:0]  TOL_RESET        = 8'd6;

   typedef enum logic [MODE_W-1:0] {
      MODE_HOLD_FWD = 3'd0,
      MODE_HOLD_REV = 3'd1,
      MODE_TURN     = 3'd2,
      MODE_OPEN_FWD = 3'd3,
      MODE_OPEN_REV = 3'd4
   } drive_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DRIVE_MODE     = 3'd0,
      CSR_TARGET_HEADING = 3'd1,
      CSR_BASE_SPEED     = 3'd2,
      CSR_TURN_CW        = 3'd3,
      CSR_PROP_GAIN      = 3'd4,
      CSR_INTEG_GAIN     = 3'd5,
      CSR_DERIV_GAIN     = 3'd6,
      CSR_TURN_TOL       = 3'd7
   } csr_index_type;

   // round(65536 * exp(-k/2))
   function automatic logic [FACTOR_W-1:0] decay_factor(input logic [DECAY_IDX_W-1:0] idx);
      logic [FACTOR_W-1:0] f;
      case (idx)
         6'd0:  f = 17'd65536;
         6'd1:  f = 17'd39750;
         6'd2:  f = 17'd24109;
         6'd3:  f = 17'd14623;
         6'd4:  f = 17'd8869;
         6'd5:  f = 17'd5380;
         6'd6:  f = 17'd3263;
         6'd7:  f = 17'd1979;
         6'd8:  f = 17'd1200;
         6'd9:  f = 17'd728;
         6'd10: f = 17'd442;
         6'd11: f = 17'd268;
         6'd12: f = 17'd162;
         6'd13: f = 17'd99;
         6'd14: f = 17'd60;
         6'd15: f = 17'd36;
         6'd16: f = 17'd22;
         6'd17: f = 17'd13;
         6'd18: f = 17'd8;
         6'd19: f = 17'd5;
         6'd20: f = 17'd3;
         6'd21: f = 17'd2;
         6'd22: f = 17'd1;
         6'd23: f = 17'd1;
         default: f = '0;
      endcase
      return f;
   endfunction

   // fixed point drive value to whole pwm units, clamped to 0..255
   function automatic logic [SPEED_W-1:0] to_speed(input logic signed [SUM_W-1:0] q);
      logic signed [SUM_W-1:0] whole;
      logic [SPEED_W-1:0] s;
      whole = q >>> GAIN_FRAC_BITS;
      if (q <= 0) begin
         s = '0;
      end else if (whole > SUM_W'(SPEED_MAX)) begin
         s = SPEED_W'(SPEED_MAX);
      end else begin
         s = whole[SPEED_W-1:0];
      end
      return s;
   endfunction

endpackage

### hw/rtl/heading_hold_drive_controller.sv
// heading hold drive controller top level: register file, four stage datapath, handshakes
// depends on hhdc_pkg and hhdc_heading_error

// Each request carries one yaw sample and yields exactly one motor command, in order.
// A request is taken every cycle while the result side keeps up; a result is offered once
// its request has passed the input register, error and controller state stage, multiplier
// stage and the mix and clamp stage that feeds the result register. The pace is set
// by the controller state loop: integrator, last error, decay step and the done flag are
// read and rewritten together in the error stage, so the next request already sees
// them. Every stage holds its item until the next stage frees, so a stalled result does
// not block requests until the pipeline is full. Hold modes run a PID on the wrapped
// whole-degree error (Q4.8 gains, saturating integrator) and mix it into base speed with
// a right motor trim of -3; turn mode spins at a decaying speed plus 35 until the error
// is within tolerance and then latches stopped with turn_done set until restart.
// The user must write configuration via csr_write_en/csr_index/csr_wdata only while idle; the block does not check.

module heading_hold_drive_controller (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_write_en,
   input  logic [hhdc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hhdc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [hhdc_pkg::HEADING_W-1:0]     req_yaw_angle,
   input  logic                               req_restart,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [hhdc_pkg::SPEED_W-1:0]       rsp_right_speed,
   output logic                               rsp_right_reverse,
   output logic [hhdc_pkg::SPEED_W-1:0]       rsp_left_speed,
   output logic                               rsp_left_reverse,
   output logic                               rsp_turn_done
);

   localparam int IW = hhdc_pkg::INTEGRAL_WIDTH;
   localparam int SW = hhdc_pkg::SUM_W;

   // ---------------- configuration registers
   hhdc_pkg::drive_mode_type             drive_mode_ff;
   logic [hhdc_pkg::HEADING_W-1:0]       target_heading_ff;
   logic [hhdc_pkg::SPEED_W-1:0]         base_speed_ff;
   logic                                 turn_cw_ff;
   logic [hhdc_pkg::GAIN_W-1:0]          prop_gain_ff;
   logic [hhdc_pkg::GAIN_W-1:0]          integ_gain_ff;
   logic [hhdc_pkg::GAIN_W-1:0]          deriv_gain_ff;
   logic [hhdc_pkg::TOL_W-1:0]           turn_tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_mode_ff     <= hhdc_pkg::MODE_OPEN_FWD;
         target_heading_ff <= '0;
         base_speed_ff     <= '0;
         turn_cw_ff        <= 1'b1;
         prop_gain_ff      <= hhdc_pkg::PROP_GAIN_RESET;
         integ_gain_ff     <= '0;
         deriv_gain_ff     <= hhdc_pkg::DERIV_GAIN_RESET;
         turn_tol_ff       <= hhdc_pkg::TOL_RESET;
      end else if (csr_write_en) begin
         case (hhdc_pkg::csr_index_type'(csr_index))
            hhdc_pkg::CSR_DRIVE_MODE:
               drive_mode_ff <= hhdc_pkg::drive_mode_type'(csr_wdata[hhdc_pkg::MODE_W-1:0]);
            hhdc_pkg::CSR_TARGET_HEADING: target_heading_ff <= csr_wdata;
            hhdc_pkg::CSR_BASE_SPEED:     base_speed_ff <= csr_wdata[hhdc_pkg::SPEED_W-1:0];
            hhdc_pkg::CSR_TURN_CW:        turn_cw_ff <= csr_wdata[0];
            hhdc_pkg::CSR_PROP_GAIN:      prop_gain_ff <= csr_wdata[hhdc_pkg::GAIN_W-1:0];
            hhdc_pkg::CSR_INTEG_GAIN:     integ_gain_ff <= csr_wdata[hhdc_pkg::GAIN_W-1:0];
            hhdc_pkg::CSR_DERIV_GAIN:     deriv_gain_ff <= csr_wdata[hhdc_pkg::GAIN_W-1:0];
            hhdc_pkg::CSR_TURN_TOL:       turn_tol_ff <= csr_wdata[hhdc_pkg::TOL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------- stage occupancy and flow control
   // each stage loads when it is empty or its item moves on
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic adv0, adv1, adv2, adv3;
   logic take0;

   assign adv3  = !s3_valid_ff || !rsp_stall;
   assign adv2  = !s2_valid_ff || adv3;
   assign adv1  = !s1_valid_ff || adv2;
   assign adv0  = !s0_valid_ff || adv1;
   assign take0 = s0_valid_ff && adv1;   // request enters the state stage

   assign req_stall = !adv0;
   assign rsp_valid = s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (adv0) s0_valid_ff <= req_valid;
         if (adv1) s1_valid_ff <= s0_valid_ff;
         if (adv2) s2_valid_ff <= s1_valid_ff;
         if (adv3) s3_valid_ff <= s2_valid_ff;
      end
   end

   // ---------------- stage 0: input register
   logic [hhdc_pkg::HEADING_W-1:0] yaw_ff;
   logic                           restart_ff;

   always_ff @(posedge clock) begin
      if (adv0) begin
         yaw_ff     <= req_yaw_angle;
         restart_ff <= req_restart;
      end
   end

   // ---------------- stage 1: heading error and controller state
   logic signed [hhdc_pkg::ERR_W-1:0] err;

   hhdc_heading_error u_err (
      .yaw    (yaw_ff),
      .target (target_heading_ff),
      .err    (err)
   );

   logic signed [IW-1:0]                 integral_sum_ff, integral_sum_in;
   logic signed [hhdc_pkg::ERR_W-1:0]    last_error_ff, last_error_in;
   logic [hhdc_pkg::DECAY_W-1:0]         decay_step_ff, decay_step_in;
   logic                                 turn_finished_ff, turn_finished_in;

   logic signed [IW-1:0]                 isum_cur;
   logic signed [hhdc_pkg::ERR_W-1:0]    last_cur;
   logic [hhdc_pkg::DECAY_W-1:0]         decay_cur;
   logic                                 finished_cur;
   logic signed [IW:0]                   acc_wide;
   logic signed [IW-1:0]                 acc;
   logic signed [hhdc_pkg::DIFF_W-1:0]   diff;
   logic [hhdc_pkg::TOL_W-1:0]           err_mag;
   logic                                 stop;
   logic                                 decay_live;
   logic [hhdc_pkg::FACTOR_W-1:0]        factor;

   always_comb begin
      // restart clears the state ahead of this sample
      isum_cur     = restart_ff ? '0 : integral_sum_ff;
      last_cur     = restart_ff ? '0 : last_error_ff;
      decay_cur    = restart_ff ? '0 : decay_step_ff;
      finished_cur = restart_ff ? 1'b0 : turn_finished_ff;

      // saturating integrator
      acc_wide = (IW+1)'(isum_cur) + (IW+1)'(err);
      if (acc_wide[IW] != acc_wide[IW-1]) begin
         acc = acc_wide[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
      end else begin
         acc = acc_wide[IW-1:0];
      end
      diff = hhdc_pkg::DIFF_W'(err) - hhdc_pkg::DIFF_W'(last_cur);

      err_mag    = err[hhdc_pkg::ERR_W-1] ? hhdc_pkg::TOL_W'(-err) : hhdc_pkg::TOL_W'(err);
      stop       = finished_cur || (err_mag <= turn_tol_ff);
      decay_live = decay_cur < hhdc_pkg::DECAY_W'(hhdc_pkg::DECAY_STEPS);
      factor     = decay_live ? hhdc_pkg::decay_factor(decay_cur[hhdc_pkg::DECAY_IDX_W-1:0])
                              : '0;

      integral_sum_in  = isum_cur;
      last_error_in    = last_cur;
      decay_step_in    = decay_cur;
      turn_finished_in = finished_cur;
      case (drive_mode_ff)
         hhdc_pkg::MODE_HOLD_FWD, hhdc_pkg::MODE_HOLD_REV: begin
            integral_sum_in = acc;
            last_error_in   = err;
         end
         hhdc_pkg::MODE_TURN: begin
            if (stop) begin
               turn_finished_in = 1'b1;
            end else if (decay_live) begin
               decay_step_in = decay_cur + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_sum_ff  <= '0;
         last_error_ff    <= '0;
         decay_step_ff    <= '0;
         turn_finished_ff <= 1'b0;
      end else if (take0) begin
         integral_sum_ff  <= integral_sum_in;
         last_error_ff    <= last_error_in;
         decay_step_ff    <= decay_step_in;
         turn_finished_ff <= turn_finished_in;
      end
   end

   logic signed [hhdc_pkg::ERR_W-1:0]  s1_err_ff;
   logic signed [IW-1:0]               s1_acc_ff;
   logic signed [hhdc_pkg::DIFF_W-1:0] s1_diff_ff;
   logic                               s1_stop_ff;
   logic [hhdc_pkg::FACTOR_W-1:0]      s1_factor_ff;

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_err_ff    <= err;
         s1_acc_ff    <= acc;
         s1_diff_ff   <= diff;
         s1_stop_ff   <= stop;
         s1_factor_ff <= factor;
      end
   end

   // ---------------- stage 2: gain and decay multipliers
   logic signed [hhdc_pkg::PROD_P_W-1:0] p_term;
   logic signed [hhdc_pkg::PROD_I_W-1:0] i_term;
   logic signed [hhdc_pkg::PROD_D_W-1:0] d_term;
   logic [hhdc_pkg::TURN_PROD_W-1:0]     turn_prod;

   always_comb begin
      p_term    = $signed({1'b0, prop_gain_ff}) * s1_err_ff;
      i_term    = $signed({1'b0, integ_gain_ff}) * s1_acc_ff;
      d_term    = $signed({1'b0, deriv_gain_ff}) * s1_diff_ff;
      turn_prod = hhdc_pkg::TURN_PROD_W'(base_speed_ff) * hhdc_pkg::TURN_PROD_W'(s1_factor_ff);
   end

   logic signed [hhdc_pkg::PROD_P_W-1:0] s2_p_ff;
   logic signed [hhdc_pkg::PROD_I_W-1:0] s2_i_ff;
   logic signed [hhdc_pkg::PROD_D_W-1:0] s2_d_ff;
   logic [hhdc_pkg::SPEED_W-1:0]         s2_turn_spd_ff;
   logic                                 s2_stop_ff;

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_p_ff        <= p_term;
         s2_i_ff        <= i_term;
         s2_d_ff        <= d_term;
         // factor never exceeds 65536, so the shifted product fits a speed
         s2_turn_spd_ff <= turn_prod[hhdc_pkg::FACTOR_SHIFT +: hhdc_pkg::SPEED_W];
         s2_stop_ff     <= s1_stop_ff;
      end
   end

   // ---------------- stage 3: motor mix, clamp and result register
   logic signed [SW-1:0]           pid_total;
   logic signed [SW-1:0]           base_q;
   logic signed [SW-1:0]           trim_q;
   logic [hhdc_pkg::SPEED_W:0]     turn_raw;
   logic [hhdc_pkg::SPEED_W-1:0]   turn_spd;

   logic [hhdc_pkg::SPEED_W-1:0]   right_speed_ff, right_speed_in;
   logic                           right_reverse_ff, right_reverse_in;
   logic [hhdc_pkg::SPEED_W-1:0]   left_speed_ff, left_speed_in;
   logic                           left_reverse_ff, left_reverse_in;
   logic                           turn_done_ff, turn_done_in;

   always_comb begin
      pid_total = SW'(s2_p_ff) + SW'(s2_i_ff) + SW'(s2_d_ff);
      base_q    = $signed(SW'(base_speed_ff)) <<< hhdc_pkg::GAIN_FRAC_BITS;
      trim_q    = $signed(SW'(hhdc_pkg::RIGHT_TRIM)) <<< hhdc_pkg::GAIN_FRAC_BITS;

      turn_raw  = {1'b0, s2_turn_spd_ff} + (hhdc_pkg::SPEED_W+1)'(hhdc_pkg::TURN_FLOOR);
      turn_spd  = turn_raw[hhdc_pkg::SPEED_W] ? hhdc_pkg::SPEED_W'(hhdc_pkg::SPEED_MAX)
                                              : turn_raw[hhdc_pkg::SPEED_W-1:0];

      right_speed_in   = '0;
      right_reverse_in = 1'b0;
      left_speed_in    = '0;
      left_reverse_in  = 1'b0;
      turn_done_in     = 1'b0;
      case (drive_mode_ff)
         hhdc_pkg::MODE_HOLD_FWD: begin
            right_speed_in = hhdc_pkg::to_speed(base_q + pid_total - trim_q);
            left_speed_in  = hhdc_pkg::to_speed(base_q - pid_total);
         end
         hhdc_pkg::MODE_HOLD_REV: begin
            right_speed_in   = hhdc_pkg::to_speed(base_q - pid_total - trim_q);
            left_speed_in    = hhdc_pkg::to_speed(base_q + pid_total);
            right_reverse_in = 1'b1;
            left_reverse_in  = 1'b1;
         end
         hhdc_pkg::MODE_TURN: begin
            if (s2_stop_ff) begin
               turn_done_in = 1'b1;
            end else begin
               // turn speed is at least 35, so the trim cannot underflow
               right_speed_in   = turn_spd - hhdc_pkg::SPEED_W'(hhdc_pkg::RIGHT_TRIM);
               left_speed_in    = turn_spd;
               right_reverse_in = turn_cw_ff;
               left_reverse_in  = !turn_cw_ff;
            end
         end
         hhdc_pkg::MODE_OPEN_FWD: begin
            right_speed_in = base_speed_ff;
            left_speed_in  = base_speed_ff;
         end
         hhdc_pkg::MODE_OPEN_REV: begin
            right_speed_in   = base_speed_ff;
            left_speed_in    = base_speed_ff;
            right_reverse_in = 1'b1;
            left_reverse_in  = 1'b1;
         end
         default: begin
            // unused mode codes stop both motors
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         right_speed_ff   <= right_speed_in;
         right_reverse_ff <= right_reverse_in;
         left_speed_ff    <= left_speed_in;
         left_reverse_ff  <= left_reverse_in;
         turn_done_ff     <= turn_done_in;
      end
   end

   assign rsp_right_speed   = right_speed_ff;
   assign rsp_right_reverse = right_reverse_ff;
   assign rsp_left_speed    = left_speed_ff;
   assign rsp_left_reverse  = left_reverse_ff;
   assign rsp_turn_done     = turn_done_ff;

`ifndef SYNTHESIS
   // a finished turn always commands both motors stopped and forward
   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_turn_done |-> rsp_right_speed == '0 && rsp_left_speed == '0
                                     && !rsp_right_reverse && !rsp_left_reverse)
      else $error("turn_done result with motors running");

   // the done flag is set only by a request processed in turn mode
   a_done_source: assert property (@(posedge clock) disable iff (reset)
      $rose(turn_finished_ff) |-> $past(take0) && $past(drive_mode_ff == hhdc_pkg::MODE_TURN))
      else $error("turn_finished set outside turn mode");

   // decay index saturates at the step count
   a_decay_bound: assert property (@(posedge clock) disable iff (reset)
      decay_step_ff <= hhdc_pkg::DECAY_W'(hhdc_pkg::DECAY_STEPS))
      else $error("decay step beyond limit");

   // a request held in the input register is not dropped while the pipe is blocked
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      s0_valid_ff && !adv1 |=> s0_valid_ff && $stable(yaw_ff) && $stable(restart_ff))
      else $error("input register lost a request");
`endif

endmodule

### hw/rtl/hhdc_heading_error.sv
// heading error: yaw minus target, rounded to whole degrees, wrapped to [-180,180)
// depends on hhdc_pkg

module hhdc_heading_error (
   input  logic [hhdc_pkg::HEADING_W-1:0]    yaw,
   input  logic [hhdc_pkg::HEADING_W-1:0]    target,
   output logic signed [hhdc_pkg::ERR_W-1:0] err
);

   logic signed [hhdc_pkg::HEADING_W+1:0] diff_q4;
   logic                                  neg;
   logic [hhdc_pkg::HEADING_W:0]          mag_q4;
   logic [9:0]                            mag_deg;
   logic signed [10:0]                    rnd;
   logic signed [10:0]                    wrapped;

   always_comb begin
      diff_q4 = $signed({2'b00, yaw}) - $signed({2'b00, target})
              + 15'(hhdc_pkg::HALF_TURN_Q4);
      neg     = diff_q4[hhdc_pkg::HEADING_W+1];
      mag_q4  = neg ? 14'(-diff_q4) : 14'(diff_q4);
      // halves round away from zero
      mag_deg = 10'((mag_q4 + 14'd8) >> 4);
      rnd     = neg ? -$signed({1'b0, mag_deg}) : $signed({1'b0, mag_deg});
      // floor modulo, rnd always lies in [-360,720)
      if (rnd < 0) begin
         wrapped = rnd + 11'(hhdc_pkg::FULL_TURN);
      end else if (rnd >= 11'(hhdc_pkg::FULL_TURN)) begin
         wrapped = rnd - 11'(hhdc_pkg::FULL_TURN);
      end else begin
         wrapped = rnd;
      end
      err = 9'(wrapped - 11'(hhdc_pkg::HALF_TURN));
   end

endmodule
